// ----- rtl/bba_pkg.sv -----
// shared types, constants and codes of the buddy block allocator
`default_nettype none

package bba_pkg;

    // default geometry
    localparam int unsigned HEAP_BYTES_DEF      = 65536;
    localparam int unsigned NUM_ORDERS_DEF      = 11;
    localparam int unsigned MIN_BLOCK_BYTES_DEF = 32;

    // fixed field widths
    localparam int unsigned ORD_W  = 4;
    localparam int unsigned NEED_W = 5;
    localparam int unsigned THR_W  = 17;

    localparam logic [16:0] HDR_BYTES     = 17'd24;
    localparam logic [16:0] MIN_ALLOC     = 17'd64;
    localparam logic [16:0] THRESHOLD_RST = 17'd32768;

    // operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [1:0] ST_TOO_LARGE = 2'd2;
    localparam logic [1:0] ST_NOT_ALLOC = 2'd3;

    typedef struct packed {
        logic        operation;
        logic [15:0] request_bytes;
        logic [15:0] block_offset;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] granted_offset;
        logic [15:0] granted_bytes;
    } t_out_word;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SCAN_CHK,
        S_SCAN_RD,
        S_SCAN_EVAL,
        S_A_CLR,
        S_SPLIT,
        S_SP_RD,
        S_SP_WR,
        S_A_FIN,
        S_F_LOOK,
        S_MERGE,
        S_M_RD,
        S_M_EVAL,
        S_M_SETRD,
        S_M_SETWR,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic       clr_step;
        logic       load;
        logic       set_err;
        logic [1:0] err_code;
        logic       k_need;
        logic       row_first;
        logic       row_read;
        logic       row_inc;
        logic       next_order;
        logic       take_hit;
        logic       mark_write;
        logic       mark_val;
        logic       split_step;
        logic       tgt_read;
        logic       alloc_read;
        logic       alloc_fin;
        logic       free_take;
        logic       bud_target;
        logic       self_target;
        logic       merge_up;
        logic       publish;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic is_free;
        logic too_large;
        logic no_fit;
        logic bad_off;
        logic order_empty;
        logic k_top;
        logic hit;
        logic last_row;
        logic k_gt_need;
        logic entry_valid;
        logic bud_ok;
        logic tgt_bit;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- rtl/bba_ctrl.sv -----
// sequencing state machine of the buddy block allocator
`default_nettype none

module bba_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire bba_pkg::t_dp_stat i_stat,
    output bba_pkg::t_dp_cmd      o_cmd
);
    import bba_pkg::*;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.is_free) begin
                    if (i_stat.bad_off) begin
                        o_cmd.set_err  = 1'b1;
                        o_cmd.err_code = ST_NOT_ALLOC;
                        n_state        = S_DONE;
                    end else begin
                        o_cmd.alloc_read = 1'b1;
                        n_state          = S_F_LOOK;
                    end
                end else if (i_stat.too_large) begin
                    o_cmd.set_err  = 1'b1;
                    o_cmd.err_code = ST_TOO_LARGE;
                    n_state        = S_DONE;
                end else if (i_stat.no_fit) begin
                    o_cmd.set_err  = 1'b1;
                    o_cmd.err_code = ST_NO_SPACE;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.k_need = 1'b1;
                    n_state      = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                if (!i_stat.order_empty) begin
                    o_cmd.row_first = 1'b1;
                    n_state         = S_SCAN_RD;
                end else if (i_stat.k_top) begin
                    o_cmd.set_err  = 1'b1;
                    o_cmd.err_code = ST_NO_SPACE;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.next_order = 1'b1;
                end
            end
            S_SCAN_RD: begin
                o_cmd.row_read = 1'b1;
                n_state        = S_SCAN_EVAL;
            end
            S_SCAN_EVAL: begin
                if (i_stat.hit) begin
                    o_cmd.take_hit = 1'b1;
                    n_state        = S_A_CLR;
                end else if (!i_stat.last_row) begin
                    o_cmd.row_inc = 1'b1;
                    n_state       = S_SCAN_RD;
                end else if (i_stat.k_top) begin
                    o_cmd.set_err  = 1'b1;
                    o_cmd.err_code = ST_NO_SPACE;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.next_order = 1'b1;
                    n_state          = S_SCAN_CHK;
                end
            end
            S_A_CLR: begin
                o_cmd.mark_write = 1'b1;
                o_cmd.mark_val   = 1'b0;
                n_state          = S_SPLIT;
            end
            S_SPLIT: begin
                if (i_stat.k_gt_need) begin
                    o_cmd.split_step = 1'b1;
                    n_state          = S_SP_RD;
                end else begin
                    n_state = S_A_FIN;
                end
            end
            S_SP_RD: begin
                o_cmd.tgt_read = 1'b1;
                n_state        = S_SP_WR;
            end
            S_SP_WR: begin
                o_cmd.mark_write = 1'b1;
                o_cmd.mark_val   = 1'b1;
                n_state          = S_SPLIT;
            end
            S_A_FIN: begin
                o_cmd.alloc_fin = 1'b1;
                n_state         = S_DONE;
            end
            S_F_LOOK: begin
                if (i_stat.entry_valid) begin
                    o_cmd.free_take = 1'b1;
                    n_state         = S_MERGE;
                end else begin
                    o_cmd.set_err  = 1'b1;
                    o_cmd.err_code = ST_NOT_ALLOC;
                    n_state        = S_DONE;
                end
            end
            S_MERGE: begin
                if (i_stat.bud_ok) begin
                    o_cmd.bud_target = 1'b1;
                    n_state          = S_M_RD;
                end else begin
                    o_cmd.self_target = 1'b1;
                    n_state           = S_M_SETRD;
                end
            end
            S_M_RD: begin
                o_cmd.tgt_read = 1'b1;
                n_state        = S_M_EVAL;
            end
            S_M_EVAL: begin
                if (i_stat.tgt_bit) begin
                    o_cmd.mark_write = 1'b1;
                    o_cmd.mark_val   = 1'b0;
                    o_cmd.merge_up   = 1'b1;
                    n_state          = S_MERGE;
                end else begin
                    o_cmd.self_target = 1'b1;
                    n_state           = S_M_SETRD;
                end
            end
            S_M_SETRD: begin
                o_cmd.tgt_read = 1'b1;
                n_state        = S_M_SETWR;
            end
            S_M_SETWR: begin
                o_cmd.mark_write = 1'b1;
                o_cmd.mark_val   = 1'b1;
                n_state          = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/bba_dpath.sv -----
// free-mark memory, allocation table, order and offset registers, result register
`default_nettype none

module bba_dpath #(
    parameter int unsigned HEAP_BYTES      = bba_pkg::HEAP_BYTES_DEF,
    parameter int unsigned NUM_ORDERS      = bba_pkg::NUM_ORDERS_DEF,
    parameter int unsigned MIN_BLOCK_BYTES = bba_pkg::MIN_BLOCK_BYTES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire bba_pkg::t_dp_cmd   i_cmd,
    output bba_pkg::t_dp_stat       o_stat,
    input  wire bba_pkg::t_in_word  i_in_word,
    input  wire logic               i_cfg_we,
    input  wire logic [16:0]        i_cfg_wdata,
    input  wire logic               i_out_stall,
    output logic                    o_out_valid,
    output bba_pkg::t_out_word      o_out_word
);
    import bba_pkg::*;

    // geometry: the minimum block is a power of two, the heap a whole number of them
    localparam int unsigned SH         = $clog2(MIN_BLOCK_BYTES);
    localparam int unsigned SLOTS      = HEAP_BYTES >> SH;
    localparam int unsigned SLOT_W     = $clog2(SLOTS);
    localparam int unsigned SW         = ((SLOT_W > NUM_ORDERS) ? SLOT_W : NUM_ORDERS) + 1;
    localparam int unsigned TOP        = NUM_ORDERS - 1;
    localparam int unsigned MARK_DEPTH = 2 * SLOTS;
    localparam int unsigned IDX_W      = $clog2(MARK_DEPTH);
    localparam int unsigned RB         = (MARK_DEPTH < 32) ? MARK_DEPTH : 32;
    localparam int unsigned RBW        = $clog2(RB);
    localparam int unsigned ROWS       = MARK_DEPTH / RB;
    localparam int unsigned RAW        = (ROWS > 1) ? $clog2(ROWS) : 1;

    // first mark of each order
    function automatic int unsigned base_of(input int unsigned k);
        int unsigned sum;
        sum = 0;
        for (int unsigned j = 0; j < 16; j++) begin
            if (j < k) sum = sum + (SLOTS >> j);
        end
        return sum;
    endfunction

    localparam int unsigned BASE_TAB [16] = '{
        base_of(0),  base_of(1),  base_of(2),  base_of(3),
        base_of(4),  base_of(5),  base_of(6),  base_of(7),
        base_of(8),  base_of(9),  base_of(10), base_of(11),
        base_of(12), base_of(13), base_of(14), base_of(15)
    };

    localparam logic [IDX_W:0] TOP_LO = (IDX_W+1)'(BASE_TAB[TOP]);
    localparam logic [IDX_W:0] TOP_HI = (IDX_W+1)'(BASE_TAB[TOP] + (SLOTS >> TOP));

    function automatic logic [IDX_W-1:0] idx_of(input logic [ORD_W-1:0] k,
                                                 input logic [SW-1:0] s);
        return IDX_W'(BASE_TAB[k]) + IDX_W'(s >> k);
    endfunction

    // memories
    logic [RB-1:0]    r_marks [ROWS];
    logic [ORD_W:0]   r_amem  [SLOTS];
    logic [RB-1:0]    r_mrd;
    logic [ORD_W:0]   r_ard;

    // registers
    logic [THR_W-1:0]  r_thr;
    t_in_word          r_in;
    logic [NEED_W-1:0] r_need;
    logic [ORD_W-1:0]  r_k;
    logic [SW-1:0]     r_slot;
    logic [RAW-1:0]    r_row;
    logic [IDX_W-1:0]  r_tidx;
    t_out_word         r_res;
    t_out_word         r_out;
    logic              r_out_valid;
    logic [SLOT_W-1:0] r_clr;

    // combinational
    logic [16:0]       bytes, rbytes;
    logic [NEED_W-1:0] need;
    logic              bad_off;
    logic [SW-1:0]     off_slot;
    logic [IDX_W:0]    lo, cnt, hi;
    logic [RAW-1:0]    first_row, last_row;
    logic [RB-1:0]     hit_mask;
    logic [RBW-1:0]    hit_bit;
    logic [IDX_W-1:0]  hit_idx;
    logic [SW-1:0]     blockno;
    logic [SW-1:0]     bud;
    logic [ORD_W-1:0]  k_dn, ent_k;
    logic [RB-1:0]     clr_row, wr_row;
    logic [IDX_W:0]    gidx, cidx;

    // request size and order needed
    always_comb begin
        bytes  = {1'b0, r_in.request_bytes} + HDR_BYTES;
        rbytes = (bytes < MIN_ALLOC) ? MIN_ALLOC : bytes;
        need   = '0;
        for (int j = 0; j < NUM_ORDERS; j++) begin
            if ((32'(MIN_BLOCK_BYTES) << j) < 32'(rbytes)) need = NEED_W'(j + 1);
        end
        bad_off  = (r_in.block_offset[SH-1:0] != '0) ||
                   (32'(r_in.block_offset) >= HEAP_BYTES);
        off_slot = SW'(r_in.block_offset >> SH);
    end

    // row scan window of the current order
    always_comb begin
        lo        = (IDX_W+1)'(BASE_TAB[r_k]);
        cnt       = (IDX_W+1)'(SLOTS >> r_k);
        hi        = lo + cnt;
        first_row = RAW'(lo >> RBW);
        last_row  = RAW'((hi - 1'b1) >> RBW);
        hit_mask  = '0;
        for (int i = 0; i < RB; i++) begin
            gidx        = ((IDX_W+1)'(r_row) << RBW) + (IDX_W+1)'(i);
            hit_mask[i] = r_mrd[i] && (gidx >= lo) && (gidx < hi);
        end
        hit_bit = '0;
        for (int i = RB - 1; i >= 0; i--) begin
            if (hit_mask[i]) hit_bit = RBW'(i);
        end
        hit_idx = IDX_W'(((IDX_W+1)'(r_row) << RBW) + (IDX_W+1)'(hit_bit));
        blockno = SW'(hit_idx) - SW'(lo);
    end

    // merge, split and clear helpers
    always_comb begin
        bud    = r_slot ^ (SW'(1) << r_k);
        k_dn   = r_k - 1'b1;
        ent_k  = (32'(r_ard[ORD_W-1:0]) > TOP) ? ORD_W'(TOP) : r_ard[ORD_W-1:0];
        wr_row = r_mrd;
        wr_row[r_tidx[RBW-1:0]] = i_cmd.mark_val;
        for (int i = 0; i < RB; i++) begin
            cidx       = ((IDX_W+1)'(r_clr) << RBW) + (IDX_W+1)'(i);
            clr_row[i] = (cidx >= TOP_LO) && (cidx < TOP_HI);
        end
    end

    // status to controller
    always_comb begin
        o_stat.clr_last    = (r_clr == SLOT_W'(SLOTS - 1));
        o_stat.is_free     = (r_in.operation == OP_FREE);
        o_stat.too_large   = ({1'b0, bytes} >= {1'b0, r_thr});
        o_stat.no_fit      = (32'(need) >= NUM_ORDERS);
        o_stat.bad_off     = bad_off;
        o_stat.order_empty = (cnt == '0);
        o_stat.k_top       = (32'(r_k) == TOP);
        o_stat.hit         = |hit_mask;
        o_stat.last_row    = (r_row == last_row);
        o_stat.k_gt_need   = (NEED_W'(r_k) > r_need);
        o_stat.entry_valid = r_ard[ORD_W];
        o_stat.bud_ok      = (32'(r_k) < TOP) && (32'(bud) < SLOTS);
        o_stat.tgt_bit     = r_mrd[r_tidx[RBW-1:0]];
        o_stat.out_free    = !r_out_valid || !i_out_stall;
    end

    // free-mark memory, one row port each way
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step && ((SLOT_W+1)'(r_clr) < (SLOT_W+1)'(ROWS))) begin
            r_marks[r_clr[RAW-1:0]] <= clr_row;
        end else if (i_cmd.mark_write) begin
            r_marks[RAW'(r_tidx >> RBW)] <= wr_row;
        end
        if (i_cmd.row_read) begin
            r_mrd <= r_marks[r_row];
        end else if (i_cmd.tgt_read) begin
            r_mrd <= r_marks[RAW'(r_tidx >> RBW)];
        end
    end

    // allocation table: valid bit and order per minimum slot
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_amem[r_clr] <= '0;
        end else if (i_cmd.alloc_fin) begin
            r_amem[r_slot[SLOT_W-1:0]] <= {1'b1, r_need[ORD_W-1:0]};
        end else if (i_cmd.free_take) begin
            r_amem[r_slot[SLOT_W-1:0]] <= '0;
        end
        if (i_cmd.alloc_read) begin
            r_ard <= r_amem[off_slot[SLOT_W-1:0]];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= THRESHOLD_RST;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_thr <= i_cfg_wdata;
            if (i_cmd.clr_step) r_clr <= r_clr + 1'b1;
            if (i_cmd.publish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_in <= i_in_word;
        if (i_cmd.k_need) begin
            r_need <= need;
            r_k    <= need[ORD_W-1:0];
        end
        if (i_cmd.next_order) r_k <= r_k + 1'b1;
        if (i_cmd.row_first) r_row <= first_row;
        if (i_cmd.row_inc) r_row <= r_row + 1'b1;
        if (i_cmd.take_hit) begin
            r_slot <= blockno << r_k;
            r_tidx <= hit_idx;
        end
        if (i_cmd.split_step) begin
            r_k    <= k_dn;
            r_tidx <= idx_of(k_dn, r_slot) + 1'b1;
        end
        if (i_cmd.alloc_read) r_slot <= off_slot;
        if (i_cmd.free_take) r_k <= ent_k;
        if (i_cmd.bud_target) r_tidx <= idx_of(r_k, bud);
        if (i_cmd.self_target) r_tidx <= idx_of(r_k, r_slot);
        if (i_cmd.merge_up) begin
            r_slot <= r_slot & ~(SW'(1) << r_k);
            r_k    <= r_k + 1'b1;
        end
        // result word
        if (i_cmd.set_err) begin
            r_res.status         <= i_cmd.err_code;
            r_res.granted_offset <= '0;
            r_res.granted_bytes  <= '0;
        end else if (i_cmd.alloc_fin) begin
            r_res.status         <= ST_OK;
            r_res.granted_offset <= 16'(32'(r_slot) << SH);
            r_res.granted_bytes  <= 16'(32'(MIN_BLOCK_BYTES) << r_need);
        end else if (i_cmd.free_take) begin
            r_res.status         <= ST_OK;
            r_res.granted_offset <= r_in.block_offset;
            r_res.granted_bytes  <= 16'(32'(MIN_BLOCK_BYTES) << ent_k);
        end
        if (i_cmd.publish) r_out <= r_res;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

`default_nettype wire

// ----- rtl/buddy_block_allocator.sv -----
// top level of the buddy block allocator
//
//  channel  | handshake             | word
//  ---------+-----------------------+-----------------------------------------
//  in       | i_in_valid/o_in_stall | operation, request_bytes, block_offset
//  out      | o_out_valid/i_out_stall | status, granted_offset, granted_bytes
//  cfg      | i_cfg_we              | large_threshold (17 bits)
//
// after reset a clearing pass over the HEAP_BYTES/MIN_BLOCK_BYTES slots (2048 by default)
// sets up the free marks and allocation table; input stalls until it is done.
// a request refused at decode, or a free of an unallocated slot, goes straight to the result;
// an allocate scans the mark rows of its order and then of higher orders and splits the found
// block down to the order needed; a free merges with each free buddy, order by order, and
// then sets the mark of the merged block.
// one word is in work at a time; a finished word waits in the output register.
// the next word is taken while the output waits; the result stage holds if it is stalled.
`default_nettype none

module buddy_block_allocator #(
    parameter int unsigned HEAP_BYTES      = bba_pkg::HEAP_BYTES_DEF,
    parameter int unsigned NUM_ORDERS      = bba_pkg::NUM_ORDERS_DEF,
    parameter int unsigned MIN_BLOCK_BYTES = bba_pkg::MIN_BLOCK_BYTES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire bba_pkg::t_in_word  i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output bba_pkg::t_out_word      o_out_word,
    input  wire logic               i_cfg_we,
    input  wire logic [16:0]        i_cfg_wdata
);
    import bba_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // sequencer
    bba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // datapath and memories
    bba_dpath #(
        .HEAP_BYTES      (HEAP_BYTES),
        .NUM_ORDERS      (NUM_ORDERS),
        .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_word   (i_in_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire
